/* rtl/core/gil_pkg.sv */
// Shared types and constants for the glyph index lookup core.
// Used by gil_ctrl, gil_datapath and glyph_index_lookup_core.
`timescale 1ns / 1ps

package gil_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int SLOT_W   = 7;
  localparam int CP_W     = 21;
  localparam int GLYPH_W  = 12;
  localparam int LEN_W    = 8;
  localparam int ENTRY_W  = CP_W + GLYPH_W;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_INDEX = 1'd1;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } gil_state_t;

  // controller -> datapath
  typedef struct packed {
    logic              mem_we;
    logic              load_query;
    logic              force_miss;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              chk_vld;
    logic              chk_first;
    logic              chk_last;
    logic              out_load;
  } gil_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CNT_W-1:0] eff_len;
    logic             dec;
  } gil_stat_t;

endpackage

/* rtl/core/gil_datapath.sv */
// Datapath: config registers, pair table memory, scan compare and result registers.
// Depends on gil_pkg; driven by gil_ctrl commands.
`timescale 1ns / 1ps

module gil_datapath import gil_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  gil_cmd_t              cmd,
  output gil_stat_t             stat,
  output logic [GLYPH_W-1:0]    out_glyph,
  output logic                  out_matched
);

  logic [LEN_W-1:0]   table_length;
  logic [GLYPH_W-1:0] replacement_index;
  logic [CNT_W-1:0]   eff_len;

  logic [SLOT_W-1:0]  in_slot;
  logic [CP_W-1:0]    in_cp;
  logic [GLYPH_W-1:0] in_glyph;
  logic               slot_ok;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data;

  logic [CP_W-1:0]    query_cp;
  logic [CP_W-1:0]    prev_start;
  logic [GLYPH_W-1:0] prev_glyph;

  logic [CP_W-1:0]    cur_start;
  logic [GLYPH_W-1:0] cur_glyph;
  logic               below;
  logic               equal;
  logic               run_ok;
  logic [GLYPH_W-1:0] gdiff;
  logic [CP_W-1:0]    off;
  logic               dec_raw;
  logic               dec;
  logic               hit;
  logic [GLYPH_W-1:0] hit_glyph;

  logic               res_matched;
  logic [GLYPH_W-1:0] res_glyph;

  assign in_slot  = s_tdata[SLOT_W-1:0];
  assign in_cp    = s_tdata[SLOT_W+CP_W-1:SLOT_W];
  assign in_glyph = s_tdata[SLOT_W+CP_W+GLYPH_W-1:SLOT_W+CP_W];
  assign slot_ok  = 32'(in_slot) < 32'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length      <= LEN_W'(1);
      replacement_index <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TABLE_LENGTH:      table_length <= cfg_data[LEN_W-1:0];
        REG_REPLACEMENT_INDEX: replacement_index <= cfg_data[GLYPH_W-1:0];
        default: ;
      endcase
    end
  end

  // lengths above the table depth saturate
  always_comb begin
    if (32'(table_length) > 32'(TABLE_DEPTH)) begin
      eff_len = CNT_W'(TABLE_DEPTH);
    end else begin
      eff_len = CNT_W'(table_length);
    end
  end

  assign stat.eff_len = eff_len;

  always_ff @(posedge clk) begin
    if (cmd.mem_we && slot_ok) begin
      mem[ADDR_W'(in_slot)] <= {in_glyph, in_cp};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      query_cp <= in_cp;
    end
    if (cmd.chk_vld) begin
      prev_start <= cur_start;
      prev_glyph <= cur_glyph;
    end
  end

  assign cur_start = rd_data[CP_W-1:0];
  assign cur_glyph = rd_data[ENTRY_W-1:CP_W];
  assign below     = query_cp < cur_start;
  assign equal     = query_cp == cur_start;
  assign run_ok    = cur_glyph > prev_glyph;
  assign gdiff     = cur_glyph - prev_glyph;
  assign off       = query_cp - prev_start;

  // pair k is on the read port; prev holds pair k-1
  always_comb begin
    dec_raw   = 1'b0;
    hit       = 1'b0;
    hit_glyph = cur_glyph;
    if (below) begin
      dec_raw = 1'b1;
      if (!cmd.chk_first) begin
        hit       = run_ok && (off < CP_W'(gdiff));
        hit_glyph = prev_glyph + off[GLYPH_W-1:0];
      end
    end else if (cmd.chk_last) begin
      // final pair covers only its own start
      dec_raw = 1'b1;
      hit     = equal;
    end
  end

  assign dec      = cmd.chk_vld && dec_raw;
  assign stat.dec = dec;

  always_ff @(posedge clk) begin
    if (cmd.force_miss) begin
      res_matched <= 1'b0;
    end else if (dec) begin
      res_matched <= hit;
      res_glyph   <= hit_glyph;
    end
    if (cmd.out_load) begin
      out_matched <= res_matched;
      out_glyph   <= res_matched ? res_glyph : replacement_index;
    end
  end

endmodule

/* rtl/core/gil_ctrl.sv */
// Controller FSM: accepts items, sequences the table scan, owns the output valid.
// Depends on gil_pkg; drives gil_datapath through gil_cmd_t.
`timescale 1ns / 1ps

module gil_ctrl import gil_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  logic      s_tuser,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  gil_stat_t stat,
  output gil_cmd_t  cmd
);

  gil_state_t       state, state_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic             chk_vld, chk_first, chk_last;
  logic             m_tvalid_next;
  logic             acc;
  logic             out_free;

  assign s_tready = state == S_IDLE;
  assign acc      = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc && s_tuser == FUNC_LOOKUP) begin
          state_next = (stat.eff_len == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.dec) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.mem_we     = acc && s_tuser == FUNC_WRITE;
    cmd.load_query = acc && s_tuser == FUNC_LOOKUP;
    cmd.force_miss = cmd.load_query && stat.eff_len == '0;
    cmd.rd_en      = state == S_SCAN && rd_idx < stat.eff_len && !stat.dec;
    cmd.rd_addr    = rd_idx[ADDR_W-1:0];
    cmd.chk_vld    = chk_vld;
    cmd.chk_first  = chk_first;
    cmd.chk_last   = chk_last;
    cmd.out_load   = state == S_DONE && out_free;
  end

  always_comb begin
    rd_idx_next = rd_idx;
    if (cmd.load_query) begin
      rd_idx_next = '0;
    end else if (cmd.rd_en) begin
      rd_idx_next = rd_idx + CNT_W'(1);
    end
    m_tvalid_next = m_tvalid;
    if (cmd.out_load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_idx   <= '0;
      chk_vld  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_idx   <= rd_idx_next;
      chk_vld  <= cmd.rd_en;
      m_tvalid <= m_tvalid_next;
    end
  end

  // tags travel with the registered read data
  always_ff @(posedge clk) begin
    chk_first <= rd_idx == '0;
    chk_last  <= rd_idx == stat.eff_len - CNT_W'(1);
  end

  a_last_decides: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && chk_vld && chk_last) |-> stat.dec)
    else $error("last pair checked without a decision");

  a_dec_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && stat.dec) |=> state == S_DONE)
    else $error("decision did not end the scan");

  a_idle_no_inflight: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !chk_vld)
    else $error("read still in flight while idle");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_DONE)
    else $error("result raised outside the done state");

endmodule

/* rtl/core/glyph_index_lookup_core.sv */
// Top level of the glyph index lookup core.
// Depends on gil_pkg, gil_ctrl and gil_datapath.
`timescale 1ns / 1ps

// Maps a code point to a glyph index through a table of (start point, first
// glyph) pairs held in a single-port-read memory. A write transfer (tuser 0)
// fills one slot and gives no result. A lookup transfer (tuser 1) scans the
// table one pair per cycle through the memory read port and stops at the
// first pair that decides, so it reads at most the effective length
// (table_length, capped at 128) of pairs; a zero length skips the scan and
// answers with the replacement index. The input is taken again once the
// result sits in the output register, so a pending result does not block the
// next item. Table slots come up unwritten after reset and must be written
// before a lookup reaches them.

module glyph_index_lookup_core import gil_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // entry_slot, code_point, entry_glyph
  input  logic                   s_tuser,   // func
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // glyph_index, zero pad
  output logic                   m_tuser    // matched
);

  gil_cmd_t           cmd;
  gil_stat_t          stat;
  logic [GLYPH_W-1:0] out_glyph;

  gil_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gil_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tdata     (s_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .out_glyph   (out_glyph),
    .out_matched (m_tuser)
  );

  assign m_tdata = OUT_TDATA_W'(out_glyph);

endmodule

/* verif/testbench.sv */
// Self-checking testbench for glyph_index_lookup_core: fills range tables,
// runs lookups under random stalls and checks each result against a model.
// Depends on gil_pkg and the glyph_index_lookup_core RTL.
`timescale 1ns / 1ps

module testbench;
  import gil_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int ITEM_TARGET   = 1850;
  localparam int MAX_GAP       = 11;
  localparam int CP_MAX        = 21'h10FFFF;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic               hit;
  } glyph_result_t;

  // Keeps a copy of the range table and registers, predicts every lookup.
  class glyph_map_model;
    logic [CP_W-1:0]    start_pts[TABLE_DEPTH];
    logic [GLYPH_W-1:0] first_glyphs[TABLE_DEPTH];
    logic [LEN_W-1:0]   table_len;
    logic [GLYPH_W-1:0] repl_glyph;
    glyph_result_t      pending_glyphs[$];
    int                 errors;
    int                 checked;
    int                 hits;

    function new();
      table_len  = 1;
      repl_glyph = '0;
      errors     = 0;
      checked    = 0;
      hits       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_TABLE_LENGTH) begin
        table_len = val[LEN_W-1:0];
      end else begin
        repl_glyph = val[GLYPH_W-1:0];
      end
    endfunction

    function glyph_result_t lookup_glyph(logic [CP_W-1:0] cp);
      int unsigned   n;
      int unsigned   i;
      int unsigned   off;
      int unsigned   g;
      int unsigned   gn;
      glyph_result_t r;
      r.glyph = repl_glyph;
      r.hit   = 1'b0;
      n = table_len;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      if (n == 0 || cp < start_pts[0]) return r;
      for (i = 0; i + 1 < n; i++) begin
        if (cp < start_pts[i+1]) begin
          g  = first_glyphs[i];
          gn = first_glyphs[i+1];
          // a run with no glyphs covers nothing
          if (gn <= g) return r;
          off = cp - start_pts[i];
          if (off > gn - g - 1) return r;
          r.glyph = GLYPH_W'(g + off);
          r.hit   = 1'b1;
          return r;
        end
      end
      // the last pair only covers its own start point
      if (start_pts[n-1] == cp) begin
        r.glyph = first_glyphs[n-1];
        r.hit   = 1'b1;
      end
      return r;
    endfunction

    function void note_item(logic func, logic [SLOT_W-1:0] slot, logic [CP_W-1:0] cp,
                            logic [GLYPH_W-1:0] eg);
      if (func == FUNC_WRITE) begin
        start_pts[slot]    = cp;
        first_glyphs[slot] = eg;
      end else begin
        pending_glyphs.push_back(lookup_glyph(cp));
      end
    endfunction

    function void check_glyph(logic [GLYPH_W-1:0] glyph, logic hit);
      glyph_result_t want;
      if (pending_glyphs.size() == 0) begin
        $display("%0t: result with none expected: expected none, got glyph %0d matched %0b",
                 $time, glyph, hit);
        errors++;
        return;
      end
      want = pending_glyphs.pop_front();
      checked++;
      if (want.hit) hits++;
      if (glyph !== want.glyph) begin
        $display("%0t: glyph_index mismatch: expected %0d, got %0d", $time, want.glyph, glyph);
        errors++;
      end
      if (hit !== want.hit) begin
        $display("%0t: matched mismatch: expected %0b, got %0b", $time, want.hit, hit);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  glyph_map_model model;
  int  items_sent = 0;
  int  settings   = 0;
  int  stall_left = 0;
  bit  tx_quiet   = 1'b0;
  bit  rx_quiet   = 1'b0;

  glyph_index_lookup_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // result side: random ready stalls, checks at the rising edge
  always @(negedge clk) begin
    m_tready = (stall_left == 0);
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      model.check_glyph(m_tdata[GLYPH_W-1:0], m_tuser);
      stall_left = draw_gap(rx_quiet);
    end
  end

  task automatic send_item(logic func, logic [SLOT_W-1:0] slot, logic [CP_W-1:0] cp,
                           logic [GLYPH_W-1:0] eg);
    int gap;
    gap = draw_gap(tx_quiet);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = func;
    s_tdata  = {eg, cp, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model.note_item(func, slot, cp, eg);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (model.pending_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    model.set_reg(idx, val);
  endtask

  // sorted table with mostly short runs, some empty runs and duplicate starts
  task automatic fill_table(int n);
    int unsigned st;
    int unsigned gl;
    int          i;
    st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, CP_MAX - 8000) : $urandom_range(0, 40);
    gl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3000) : $urandom_range(0, 50);
    for (i = 0; i < n; i++) begin
      send_item(FUNC_WRITE, SLOT_W'(i), CP_W'(st), GLYPH_W'(gl));
      case ($urandom_range(0, 19))
        0:       st = st;
        1:       st = st + $urandom_range(1, 4000);
        default: st = st + $urandom_range(1, 16);
      endcase
      if (st > CP_MAX) st = CP_MAX;
      case ($urandom_range(0, 19))
        0:       gl = gl;
        1:       gl = $urandom_range(0, 4095);
        default: gl = gl + $urandom_range(1, 12);
      endcase
      if (gl > 4095) gl = 4095;
    end
  endtask

  task automatic run_lookups(int n, int eff_len);
    int          k;
    int unsigned idx;
    int unsigned cp;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0, 1:    cp = $urandom_range(0, CP_MAX);
        2:       cp = $urandom_range(0, 21'h1FFFFF);
        3, 4: begin
          send_item(FUNC_WRITE, SLOT_W'($urandom_range(0, TABLE_DEPTH - 1)),
                    CP_W'($urandom_range(0, CP_MAX)), GLYPH_W'($urandom_range(0, 4095)));
          continue;
        end
        default: begin
          if (eff_len == 0) begin
            cp = $urandom_range(0, CP_MAX);
          end else begin
            idx = $urandom_range(0, eff_len - 1);
            cp  = model.start_pts[idx];
            if ($urandom_range(0, 5) == 0 && cp > 0) cp = cp - 1;
            else cp = cp + $urandom_range(0, 14);
          end
        end
      endcase
      send_item(FUNC_LOOKUP, SLOT_W'($urandom), CP_W'(cp), GLYPH_W'($urandom));
    end
  endtask

  initial begin
    int len;
    int eff_len;
    int repl;
    model = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset length of one, exact match on the last pair
    send_item(FUNC_WRITE, 7'd0, 21'h41, 12'd5);
    send_item(FUNC_LOOKUP, 7'd0, 21'h41, 12'd0);
    send_item(FUNC_LOOKUP, 7'd0, 21'h42, 12'd0);
    send_item(FUNC_LOOKUP, 7'd0, 21'h0, 12'd0);
    // zero length always gives the replacement
    wait_idle();
    write_reg(REG_TABLE_LENGTH, 12'd0);
    write_reg(REG_REPLACEMENT_INDEX, 12'hFFF);
    send_item(FUNC_LOOKUP, 7'd0, 21'h41, 12'd0);
    wait_idle();
    write_reg(REG_TABLE_LENGTH, 12'd3);
    send_item(FUNC_WRITE, 7'd0, 21'h0, 12'h000);
    send_item(FUNC_WRITE, 7'd1, 21'h100, 12'hFF0);
    send_item(FUNC_WRITE, 7'd2, 21'h10FFFF, 12'hFFF);
    send_item(FUNC_LOOKUP, 7'd0, 21'h0, 12'd0);
    send_item(FUNC_LOOKUP, 7'd0, 21'hFF, 12'd0);
    send_item(FUNC_LOOKUP, 7'd0, 21'h100, 12'd0);
    send_item(FUNC_LOOKUP, 7'd0, 21'h10E, 12'd0);
    send_item(FUNC_LOOKUP, 7'd0, 21'h10F, 12'd0);
    send_item(FUNC_LOOKUP, 7'd0, 21'h10FFFF, 12'd0);
    // glyphs not increasing: empty run
    send_item(FUNC_WRITE, 7'd1, 21'h100, 12'h000);
    send_item(FUNC_LOOKUP, 7'd0, 21'h5, 12'd0);
    send_item(FUNC_WRITE, 7'd127, 21'h1FFFFF, 12'hFFF);
    settings = 3;

    // random phases, extremes of the length register first
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      case (settings)
        3:       len = 128;
        4:       len = 255;
        5:       len = 0;
        6:       len = 1;
        default: begin
          case ($urandom_range(0, 19))
            0:       len = 0;
            1:       len = 128;
            2:       len = $urandom_range(129, 255);
            3, 4:    len = $urandom_range(17, 127);
            default: len = $urandom_range(1, 16);
          endcase
        end
      endcase
      case ($urandom_range(0, 5))
        0:       repl = 0;
        1:       repl = 4095;
        default: repl = $urandom_range(0, 4095);
      endcase
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_TABLE_LENGTH, CFG_DATA_W'(len));
        write_reg(REG_REPLACEMENT_INDEX, CFG_DATA_W'(repl));
      end else begin
        write_reg(REG_REPLACEMENT_INDEX, CFG_DATA_W'(repl));
        write_reg(REG_TABLE_LENGTH, CFG_DATA_W'(len));
      end
      settings++;
      eff_len = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
      fill_table(eff_len);
      run_lookups($urandom_range(10, 40), eff_len);
    end

    wait_idle();
    $display("Covered %0d input transfers over %0d register settings.", items_sent, settings);
    $display("Checked %0d lookups: %0d table hits, %0d replacements.",
             model.checked, model.hits, model.checked - model.hits);
    if (model.errors == 0 && model.pending_glyphs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/gil_pkg.sv
rtl/core/gil_datapath.sv
rtl/core/gil_ctrl.sv
rtl/core/glyph_index_lookup_core.sv
verif/testbench.sv
